// ===== rtl/rank_filter_3x3_assert.svh =====
// Assertion macros used by the checker file of the rank filter.
`ifndef RANK_FILTER_3X3_ASSERT_SVH
`define RANK_FILTER_3X3_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle while rst_n is low.
`define RF_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("rank filter check failed");

// Next-cycle implication, sampled on clk and idle while rst_n is low.
`define RF_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("rank filter check failed");

`endif

// ===== rtl/rf_pkg.sv =====
package rf_pkg;

    // Pixel and window geometry.
    localparam int PIX_W = 8;
    localparam int WIN_N = 9;

    // Configuration register widths, limits and reset values.
    localparam int CFG_W      = 11;
    localparam int RANK_W     = 4;
    localparam int MIN_SIZE   = 3;
    localparam int RANK_MAX   = 8;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam logic [CFG_W-1:0]  WIDTH_RST  = CFG_W'(7);
    localparam logic [CFG_W-1:0]  HEIGHT_RST = CFG_W'(7);
    localparam logic [RANK_W-1:0] RANK_RST   = RANK_W'(4);

    // Register port.
    localparam int APB_DATA_W = 32;
    localparam int RF_ADDR_W  = 4;
    localparam int REG_IDX_W  = 2;

    // Register indexes (byte address divided by four).
    localparam logic [REG_IDX_W-1:0] RF_REG_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] RF_REG_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] RF_REG_RANK   = 2'd2;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [CFG_W-1:0] cfg_t;
    typedef logic [RANK_W-1:0] rank_t;
    typedef logic [WIN_N-1:0][PIX_W-1:0] win_vec_t;

    // Control that travels with a window through the sorting cells.
    typedef struct packed {
        logic valid;
        logic last;
    } rf_ctl_t;

endpackage

// ===== rtl/rank_filter_3x3.sv =====
// Channel    | Signals                      | Contents
// input      | s_axis_tvalid/tready/tdata   | tdata[7:0] pixel_in, raster order
// output     | m_axis_tvalid/tready/tdata   | tdata[7:0] pixel_out, tlast frame_last
// registers  | psel/penable/pwrite/paddr    | 0x0 line_width, 0x4 frame_height, 0x8 rank
//
// One pixel is taken per clock unless a stall holds the pipeline; a result comes
// from the line store read stage, nine sorting cells and the output register.
// Border pixels leave the pipeline after the line store stage and yield no result.
// Reset clears counters, window columns and valid flags; line stores are not cleared.
// A stalled output only stops the stages behind it that are full; bubbles still fill.
module rank_filter_3x3 #(
    parameter int MAX_WIDTH  = rf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] pixel_in
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // [7:0] pixel_out
    output logic                            m_axis_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rf_pkg::RF_ADDR_W-1:0]    paddr,
    input  logic [rf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                            pready
);

    import rf_pkg::*;

    cfg_t  width_reg;
    cfg_t  height_reg;
    rank_t rank_reg;
    logic  cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;

    rf_ctl_t  chain_ctl   [WIN_N + 1];
    win_vec_t chain_data  [WIN_N + 1];
    logic     chain_ready [WIN_N + 1];

    logic  out_valid_reg;
    logic  out_last_reg;
    pix_t  out_pix_reg;
    logic  out_load;
    rank_t rank_idx;

    // Register port: no wait states.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[RF_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            rank_reg   <= RANK_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                RF_REG_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                RF_REG_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                RF_REG_RANK:   rank_reg   <= pwdata[RANK_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            RF_REG_WIDTH:  prdata = APB_DATA_W'(width_reg);
            RF_REG_HEIGHT: prdata = APB_DATA_W'(height_reg);
            RF_REG_RANK:   prdata = APB_DATA_W'(rank_reg);
            default:       prdata = '0;
        endcase
    end

    // Line stores, counters and window columns.
    rf_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_pixel     (s_axis_tdata),
        .line_width   (width_reg),
        .frame_height (height_reg),
        .win_ready    (chain_ready[0]),
        .win_ctl      (chain_ctl[0]),
        .win_data     (chain_data[0])
    );

    // Nine alternating phases sort the nine window values.
    for (genvar k = 0; k < WIN_N; k++)
    begin : g_cell
        rf_sort_cell #(
            .ODD_PHASE (k % 2 == 1)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_ctl    (chain_ctl[k]),
            .in_data   (chain_data[k]),
            .in_ready  (chain_ready[k]),
            .out_ctl   (chain_ctl[k + 1]),
            .out_data  (chain_data[k + 1]),
            .out_ready (chain_ready[k + 1])
        );
    end

    // Output register picks the configured rank from the sorted window.
    assign rank_idx = (rank_reg > RANK_W'(RANK_MAX)) ? RANK_W'(RANK_MAX) : rank_reg;
    assign out_load = !out_valid_reg || m_axis_tready;
    assign chain_ready[WIN_N] = out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= chain_ctl[WIN_N].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && chain_ctl[WIN_N].valid)
        begin
            out_pix_reg  <= chain_data[WIN_N][rank_idx];
            out_last_reg <= chain_ctl[WIN_N].last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pix_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== rtl/rf_ram.sv =====
module rf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rf_window.sv =====
module rf_window #(
    parameter int MAX_WIDTH  = rf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rf_pkg::DEF_MAX_HEIGHT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rf_pkg::pix_t      in_pixel,
    input  rf_pkg::cfg_t      line_width,
    input  rf_pkg::cfg_t      frame_height,
    input  logic              win_ready,
    output rf_pkg::rf_ctl_t   win_ctl,
    output rf_pkg::win_vec_t  win_data
);

    import rf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WXW = (CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W : $clog2(MAX_WIDTH + 1);
    localparam int HXW = (CFG_W > $clog2(MAX_HEIGHT + 1)) ? CFG_W : $clog2(MAX_HEIGHT + 1);

    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [CW-1:0]  col_last;
    logic [RW-1:0]  row_last;
    logic [WXW-1:0] width_ext;
    logic [HXW-1:0] height_ext;
    logic           row_end;
    logic           frame_end;
    logic           accept;

    // The item whose line store read is in flight.
    logic           valid_reg;
    logic           emit_reg;
    logic           last_reg;
    pix_t           pix_reg;
    logic [CW-1:0]  addr_reg;

    logic           go;
    logic           load;
    logic [2*PIX_W-1:0] store_rdata;
    pix_t           top;
    pix_t           mid;
    pix_t           wr_reg [6];

    // Last column and last row index from the clamped frame size.
    always_comb
    begin
        width_ext  = WXW'(line_width);
        height_ext = HXW'(frame_height);
        if (width_ext < WXW'(MIN_SIZE))
        begin
            col_last = CW'(MIN_SIZE - 1);
        end
        else if (width_ext > WXW'(MAX_WIDTH))
        begin
            col_last = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            col_last = CW'(width_ext - WXW'(1));
        end
        if (height_ext < HXW'(MIN_SIZE))
        begin
            row_last = RW'(MIN_SIZE - 1);
        end
        else if (height_ext > HXW'(MAX_HEIGHT))
        begin
            row_last = RW'(MAX_HEIGHT - 1);
        end
        else
        begin
            row_last = RW'(height_ext - HXW'(1));
        end
    end

    // The held item leaves when the sorter takes it or when it yields nothing.
    assign go       = valid_reg && (win_ready || !emit_reg);
    assign load     = !valid_reg || go;
    assign in_ready = load;
    assign accept   = in_valid && load;

    assign row_end   = col_reg >= col_last;
    assign frame_end = row_reg >= row_last;

    // Raster position of the next pixel.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (load)
            begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg  <= in_pixel;
            addr_reg <= col_reg;
            emit_reg <= (row_reg >= RW'(2)) && (col_reg >= CW'(2));
            last_reg <= row_end && frame_end;
        end
    end

    // Both line stores share one entry per column: upper row high, lower row low.
    rf_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (go),
        .waddr (addr_reg),
        .wdata ({mid, pix_reg}),
        .re    (load),
        .raddr (col_reg),
        .rdata (store_rdata)
    );

    assign top = store_rdata[2*PIX_W-1:PIX_W];
    assign mid = store_rdata[PIX_W-1:0];

    // Window columns shift left as each item leaves.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                wr_reg[i] <= '0;
            end
        end
        else if (go)
        begin
            wr_reg[0] <= wr_reg[3];
            wr_reg[1] <= wr_reg[4];
            wr_reg[2] <= wr_reg[5];
            wr_reg[3] <= top;
            wr_reg[4] <= mid;
            wr_reg[5] <= pix_reg;
        end
    end

    // Window rows top, middle, bottom; columns oldest first.
    assign win_data[0] = wr_reg[0];
    assign win_data[1] = wr_reg[3];
    assign win_data[2] = top;
    assign win_data[3] = wr_reg[1];
    assign win_data[4] = wr_reg[4];
    assign win_data[5] = mid;
    assign win_data[6] = wr_reg[2];
    assign win_data[7] = wr_reg[5];
    assign win_data[8] = pix_reg;

    assign win_ctl.valid = valid_reg && emit_reg;
    assign win_ctl.last  = last_reg;

endmodule

// ===== rtl/rf_sort_cell.sv =====
module rf_sort_cell #(
    parameter bit ODD_PHASE = 1'b0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rf_pkg::rf_ctl_t   in_ctl,
    input  rf_pkg::win_vec_t  in_data,
    output logic              in_ready,
    output rf_pkg::rf_ctl_t   out_ctl,
    output rf_pkg::win_vec_t  out_data,
    input  logic              out_ready
);

    import rf_pkg::*;

    rf_ctl_t  ctl_reg;
    win_vec_t data_reg;
    win_vec_t data_next;
    logic     load;

    // One phase of odd-even transposition: compare-exchange neighbor pairs.
    always_comb
    begin
        data_next = in_data;
        for (int i = (ODD_PHASE ? 1 : 0); i + 1 < WIN_N; i += 2)
        begin
            if (in_data[i] > in_data[i + 1])
            begin
                data_next[i]     = in_data[i + 1];
                data_next[i + 1] = in_data[i];
            end
        end
    end

    assign load     = !ctl_reg.valid || out_ready;
    assign in_ready = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (load)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_ctl.valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_ctl  = ctl_reg;
    assign out_data = data_reg;

endmodule

// ===== rtl/rank_filter_3x3_checker.sv =====
`include "rank_filter_3x3_assert.svh"

module rank_filter_3x3_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [7:0]                      m_axis_tdata,
    input  logic                            m_axis_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rf_pkg::RF_ADDR_W-1:0]    paddr,
    input  logic [rf_pkg::APB_DATA_W-1:0]   pwdata,
    input  logic [rf_pkg::APB_DATA_W-1:0]   prdata,
    input  logic                            pready
);

    import rf_pkg::*;

    // A result waiting at the output holds its value and flag.
    `RF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // With the output register empty every stage can move, so input is taken.
    `RF_ASSERT_NOW(a_empty_ready, !m_axis_tvalid, s_axis_tready)

    // The register port never inserts wait states.
    `RF_ASSERT_NOW(a_no_wait, psel, pready)

    // The rank register reads back no bits above its four.
    `RF_ASSERT_NOW(a_rank_width, psel && !pwrite && paddr[RF_ADDR_W-1:2] == RF_REG_RANK,
        prdata[APB_DATA_W-1:RANK_W] == '0)

endmodule

bind rank_filter_3x3 rank_filter_3x3_checker u_checker (.*);

// ===== verif/rank_filter_3x3_monitor.sv =====
// Watches the pixel, result and register channels of the rank filter.
// Keeps its own copy of the line stores, window columns and counters, works
// out the ranked value for every accepted pixel that completes an interior
// window, and compares each accepted result with the oldest one waiting.
module rank_filter_3x3_monitor
    import rf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] pixel_in
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata,    // [7:0] pixel_out
    input  logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [RF_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    pending,
    output int                    results_seen,
    output int                    fail_count
);

    localparam int LINE_DEPTH = DEF_MAX_WIDTH;

    typedef struct packed {
        pix_t value;
        logic last;
    } ranked_pix_t;

    cfg_t        width_reg  = WIDTH_RST;
    cfg_t        height_reg = HEIGHT_RST;
    rank_t       rank_reg   = RANK_RST;
    pix_t        two_rows_up [LINE_DEPTH];
    pix_t        one_row_up [LINE_DEPTH];
    pix_t        left_cols [6];
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    ranked_pix_t ranked_q [$];

    initial
    begin
        pending      = 0;
        results_seen = 0;
        fail_count   = 0;
    end

    function automatic int unsigned size_in_use(cfg_t raw, int unsigned hi);
        if (raw < MIN_SIZE)
            return MIN_SIZE;
        if (raw > hi)
            return hi;
        return raw;
    endfunction

    // A value sits at the wanted rank when fewer than rank+1 values lie
    // strictly below it and more than rank values lie at or below it.
    function automatic pix_t window_rank(pix_t win [WIN_N], rank_t sel);
        int unsigned pos;
        int unsigned below;
        int unsigned not_above;
        pix_t        pick;
        pos  = (sel > RANK_MAX) ? RANK_MAX : sel;
        pick = win[0];
        for (int i = 0; i < WIN_N; i++)
        begin
            below     = 0;
            not_above = 0;
            for (int j = 0; j < WIN_N; j++)
            begin
                if (win[j] < win[i])
                    below++;
                if (win[j] <= win[i])
                    not_above++;
            end
            if (below <= pos && pos < not_above)
                pick = win[i];
        end
        return pick;
    endfunction

    // One pixel moves through the line stores and window columns.
    task automatic take_pixel(pix_t bot);
        int unsigned w;
        int unsigned h;
        pix_t        top;
        pix_t        mid;
        pix_t        win [WIN_N];
        logic        row_end;
        logic        frame_end;
        ranked_pix_t item;
        w         = size_in_use(width_reg, DEF_MAX_WIDTH);
        h         = size_in_use(height_reg, DEF_MAX_HEIGHT);
        row_end   = (col_pos >= w - 1);
        frame_end = (row_pos >= h - 1);
        top       = '0;
        mid       = '0;
        if (col_pos < LINE_DEPTH)
        begin
            top                  = two_rows_up[col_pos];
            mid                  = one_row_up[col_pos];
            two_rows_up[col_pos] = mid;
            one_row_up[col_pos]  = bot;
        end
        win = '{left_cols[0], left_cols[1], left_cols[2], left_cols[3], left_cols[4],
                left_cols[5], top, mid, bot};
        if (row_pos >= 2 && col_pos >= 2)
        begin
            item.value = window_rank(win, rank_reg);
            item.last  = row_end && frame_end;
            ranked_q.push_back(item);
        end
        left_cols[0] = left_cols[3];
        left_cols[1] = left_cols[4];
        left_cols[2] = left_cols[5];
        left_cols[3] = top;
        left_cols[4] = mid;
        left_cols[5] = bot;
        if (row_end)
        begin
            col_pos = 0;
            row_pos = frame_end ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
    endtask

    // Sample all three channels at the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        ranked_pix_t want;
        if (!rst_n)
        begin
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            rank_reg   = RANK_RST;
            for (int i = 0; i < LINE_DEPTH; i++)
            begin
                two_rows_up[i] = '0;
                one_row_up[i]  = '0;
            end
            for (int i = 0; i < 6; i++)
                left_cols[i] = '0;
            col_pos = 0;
            row_pos = 0;
            ranked_q.delete();
            pending = 0;
        end
        else
        begin
            // Register writes.
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[RF_ADDR_W-1:2])
                    RF_REG_WIDTH:  width_reg  = pwdata[CFG_W-1:0];
                    RF_REG_HEIGHT: height_reg = pwdata[CFG_W-1:0];
                    RF_REG_RANK:   rank_reg   = pwdata[RANK_W-1:0];
                    default: ;
                endcase
            end

            // Results against the oldest expectation.
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (ranked_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result %0d last %0b arrived with none expected",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = ranked_q.pop_front();
                    if (m_tdata !== want.value)
                    begin
                        fail_count++;
                        $display("%0t: pixel_out expected %0d, got %0d",
                                 $time, want.value, m_tdata);
                    end
                    if (m_tlast !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: frame_last expected %0b, got %0b",
                                 $time, want.last, m_tlast);
                    end
                end
            end

            if (s_tvalid && s_tready)
                take_pixel(s_tdata);
            pending = ranked_q.size();
        end
    end

endmodule

// ===== verif/tb_rank_filter_3x3.sv =====
// Drives frames of pixels and register settings into the rank filter and
// gives the verdict from the failure count of the monitor.
module tb_rank_filter_3x3;
    import rf_pkg::*;

    localparam int RANDOM_ITEMS   = 860;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int WIDE_COLS      = 40;
    localparam int TALL_ROWS      = 6;

    typedef enum int {
        PIX_NOISE,
        PIX_EXTREME,
        PIX_FLAT,
        PIX_BITS
    } pix_style_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;    // [7:0] pixel_in
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;          // [7:0] pixel_out
    logic                  m_axis_tlast;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [RF_ADDR_W-1:0]  paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int          pending;
    int          results_seen;
    int          fail_count;
    int          sent        = 0;
    int          frames      = 0;
    int          send_odds   = 0;
    int          sink_odds   = 0;
    bit          hold_req    = 1'b0;
    int          quiet_count = 0;
    cfg_t        stim_width  = WIDTH_RST;
    cfg_t        stim_height = HEIGHT_RST;
    int unsigned col_pos     = 0;
    int unsigned row_pos     = 0;

    always #1 clk = ~clk;

    rank_filter_3x3 i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    rank_filter_3x3_monitor i_monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_axis_tvalid),
        .s_tready     (s_axis_tready),
        .s_tdata      (s_axis_tdata),
        .m_tvalid     (m_axis_tvalid),
        .m_tready     (m_axis_tready),
        .m_tdata      (m_axis_tdata),
        .m_tlast      (m_axis_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pending      (pending),
        .results_seen (results_seen),
        .fail_count   (fail_count)
    );

    // Watchdog: too many cycles without any item or register write moving.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired at %0t with %0d results outstanding", $time, pending);
            $display("rank_filter_3x3: mismatch");
            $finish;
        end
    end

    // Result receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin : receiver
        bit hold_done;
        int stall;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (sink_odds != 0 && $urandom_range(1, sink_odds) == 1)
            begin
                stall = $urandom_range(1, 6);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic int unsigned size_in_use(cfg_t raw, int unsigned hi);
        if (raw < MIN_SIZE)
            return MIN_SIZE;
        if (raw > hi)
            return hi;
        return raw;
    endfunction

    function automatic pix_t next_pixel(pix_style_t style, pix_t base);
        case (style)
            PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            PIX_FLAT:    return base + pix_t'($urandom_range(0, 3));
            PIX_BITS:
            begin
                if ($urandom_range(0, 1))
                    return 8'h01 << $urandom_range(0, 7);
                return ~(8'h01 << $urandom_range(0, 7));
            end
            default:     return pix_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_odds();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 2;
            2:       return 4;
            default: return 10;
        endcase
    endfunction

    task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RF_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            RF_REG_WIDTH:  stim_width  = value[CFG_W-1:0];
            RF_REG_HEIGHT: stim_height = value[CFG_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one pixel, with an optional gap first, and track the frame position.
    task automatic send_pixel(pix_t value);
        int gap;
        int unsigned w;
        int unsigned h;
        @(negedge clk);
        if (send_odds != 0 && $urandom_range(1, send_odds) == 1)
        begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
        w = size_in_use(stim_width, DEF_MAX_WIDTH);
        h = size_in_use(stim_height, DEF_MAX_HEIGHT);
        if (col_pos >= w - 1)
        begin
            col_pos = 0;
            if (row_pos >= h - 1)
            begin
                row_pos = 0;
                frames++;
            end
            else
            begin
                row_pos++;
            end
        end
        else
        begin
            col_pos++;
        end
    endtask

    // Sends pixels until the frame in progress (or a new one) is complete.
    task automatic finish_frame(pix_style_t style);
        pix_t base;
        base = pix_t'($urandom_range(0, 255));
        do
            send_pixel(next_pixel(style, base));
        while (col_pos != 0 || row_pos != 0);
    endtask

    // Drop valid, wait for every expected result, then let border pixels drain.
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin : stimulus
        pix_t       lead_in [17];
        pix_t       corner [9];
        pix_style_t style;
        int         cut;
        lead_in = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA, 8'h10,
                    8'h20, 8'h40, 8'h02, 8'h04, 8'h08, 8'hFF, 8'h00, 8'h33};
        corner  = '{8'hFF, 8'h00, 8'hFF, 8'h80, 8'hFF, 8'h01, 8'hFF, 8'h7F, 8'hFE};
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Reset sizes and median rank: stop just after the first interior result.
        foreach (lead_in[i])
            send_pixel(lead_in[i]);
        settle();

        // Shrink below the minimum mid-frame; the next pixel ends row and frame.
        reg_write(RF_REG_WIDTH, '0);
        reg_write(RF_REG_HEIGHT, '0);
        reg_write(RF_REG_RANK, '0);
        send_pixel(8'hC0);
        settle();

        // Smallest frame with an over-range rank, which saturates to maximum.
        reg_write(RF_REG_RANK, 32'hF);
        foreach (corner[i])
            send_pixel(corner[i]);
        settle();

        // Output held off for a long stretch while pixels keep coming.
        reg_write(RF_REG_WIDTH, 24);
        reg_write(RF_REG_HEIGHT, 6);
        reg_write(RF_REG_RANK, RANK_MAX / 2);
        hold_req = 1'b1;
        finish_frame(PIX_NOISE);
        settle();

        // Random frames; near the end both sides stop idling.
        while (sent < RANDOM_ITEMS)
        begin
            if (sent > RANDOM_ITEMS * 17 / 20)
            begin
                send_odds = 0;
                sink_odds = 0;
            end
            else
            begin
                send_odds = pick_odds();
                sink_odds = pick_odds();
            end
            if ($urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1:    reg_write(RF_REG_WIDTH, $urandom_range(0, 2));
                    2:       reg_write(RF_REG_WIDTH, $urandom_range(13, 40));
                    default: reg_write(RF_REG_WIDTH, $urandom_range(3, 12));
                endcase
            end
            if ($urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1:    reg_write(RF_REG_HEIGHT, $urandom_range(0, 2));
                    2:       reg_write(RF_REG_HEIGHT, $urandom_range(9, 16));
                    default: reg_write(RF_REG_HEIGHT, $urandom_range(3, 8));
                endcase
            end
            if ($urandom_range(0, 2) != 0)
                reg_write(RF_REG_RANK, $urandom_range(0, 15));
            style = pix_style_t'($urandom_range(0, 3));

            // Now and then the frame is cut short mid-way and a size shrinks.
            if ($urandom_range(0, 5) == 0)
            begin
                cut = $urandom_range(1, size_in_use(stim_width, DEF_MAX_WIDTH)
                                       * size_in_use(stim_height, DEF_MAX_HEIGHT) - 1);
                repeat (cut) send_pixel(next_pixel(style, 8'h40));
                settle();
                if ($urandom_range(0, 1))
                    reg_write(RF_REG_WIDTH,
                              $urandom_range(0, size_in_use(stim_width, DEF_MAX_WIDTH)));
                else
                    reg_write(RF_REG_HEIGHT,
                              $urandom_range(0, size_in_use(stim_height, DEF_MAX_HEIGHT)));
            end
            finish_frame(style);
            settle();
        end

        // Registers at all ones clamp to the largest sizes; a shrink ends each frame early.
        send_odds = 0;
        sink_odds = 0;
        reg_write(RF_REG_WIDTH, 32'h7FF);
        reg_write(RF_REG_HEIGHT, 3);
        reg_write(RF_REG_RANK, $urandom_range(0, 8));
        repeat (WIDE_COLS) send_pixel(next_pixel(PIX_NOISE, 8'h00));
        settle();
        reg_write(RF_REG_WIDTH, 3);
        finish_frame(PIX_NOISE);
        settle();
        reg_write(RF_REG_HEIGHT, 32'h7FF);
        repeat (TALL_ROWS * 3) send_pixel(next_pixel(PIX_FLAT, 8'h80));
        settle();
        reg_write(RF_REG_HEIGHT, 3);
        finish_frame(PIX_FLAT);
        settle();

        $display("Sent %0d pixels in %0d frames and checked %0d ranked results,",
                 sent, frames, results_seen);
        $display("over clamped and largest sizes, all ranks, mid-frame shrinks and stalls.");
        if (fail_count == 0)
            $display("rank_filter_3x3: match");
        else
            $display("rank_filter_3x3: mismatch");
        $finish;
    end

endmodule
